// ===== sv/esr_pkg.sv =====
package esr_pkg;

  // Node numbers in the edge table and on the ports are always 6 bits.
  localparam int NODE_ID_W = 6;
  localparam int ENTRY_W   = 2 * NODE_ID_W;
  localparam int SET_W     = 64;

  typedef struct packed {
    logic load_edge;   // write one edge table entry
    logic load_query;  // capture a query and seed both closures
    logic sweep;       // issue one edge table read
    logic restart;     // begin another pass over the edges
    logic finish;      // register the result
  } esr_cmd_t;

  typedef struct packed {
    logic last_edge;   // the read issued this cycle is the last edge
    logic changed;     // some closure grew during the current pass
  } esr_status_t;

endpackage

// ===== sv/esr_ctrl.sv =====
module esr_ctrl
  import esr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_kind,
  input  esr_status_t status,
  output esr_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    cmd.load_edge  = accept && !in_kind;
    cmd.load_query = accept && in_kind;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load_query) begin
          state_nxt = ST_SWEEP;
          busy_nxt  = 1'b1;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.last_edge) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last edge of the pass is applied in this cycle.
        if (status.changed) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_SWEEP;
        end else begin
          cmd.finish    = 1'b1;
          state_nxt     = ST_IDLE;
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== sv/esr_datapath.sv =====
module esr_datapath
  import esr_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int EDGE_COUNT = 64
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  esr_cmd_t             cmd,
  output esr_status_t          status,
  input  logic [NODE_ID_W-1:0] in_edge_index,
  input  logic [NODE_ID_W-1:0] in_edge_source,
  input  logic [NODE_ID_W-1:0] in_edge_target,
  input  logic [SET_W-1:0]     in_sure_edges,
  input  logic [SET_W-1:0]     in_absent_edges,
  input  logic [SET_W-1:0]     in_middle_edges,
  input  logic [SET_W-1:0]     in_start_nodes,
  input  logic [SET_W-1:0]     in_end_nodes,
  output logic                 out_decided,
  output logic [SET_W-1:0]     out_reached_set
);

  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int EDGE_W = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;

  logic [ENTRY_W-1:0]    edge_mem [EDGE_COUNT];
  logic [ENTRY_W-1:0]    rd_data_r;
  logic [EDGE_W-1:0]     rd_idx_r;
  logic                  rd_valid_r;
  logic [EDGE_W-1:0]     edge_cnt_r;
  logic [EDGE_COUNT-1:0] use_sure_r, use_maybe_r;
  logic [NODE_COUNT-1:0] ends_r;
  logic [NODE_COUNT-1:0] seen_sure_r, seen_sure_nxt;
  logic [NODE_COUNT-1:0] seen_maybe_r, seen_maybe_nxt;
  logic                  changed_r;
  logic                  out_decided_r;
  logic [SET_W-1:0]      out_reached_r;

  logic [NODE_ID_W-1:0]  src, dst;
  logic [NODE_W-1:0]     src_i, dst_i;
  logic                  in_range;
  logic                  hit_sure, hit_maybe;
  logic                  load_ok;
  logic [NODE_COUNT-1:0] undecided;

  assign load_ok = (NODE_ID_W'(EDGE_COUNT - 1) >= in_edge_index);

  // Edge table: one write port for loads, one registered read port for sweeps.
  always_ff @(posedge clk) begin
    if (cmd.load_edge && load_ok) begin
      edge_mem[in_edge_index[EDGE_W-1:0]] <= {in_edge_target, in_edge_source};
    end
    rd_data_r <= edge_mem[edge_cnt_r];
    rd_idx_r  <= edge_cnt_r;
  end

  assign src      = rd_data_r[NODE_ID_W-1:0];
  assign dst      = rd_data_r[ENTRY_W-1:NODE_ID_W];
  assign src_i    = src[NODE_W-1:0];
  assign dst_i    = dst[NODE_W-1:0];
  assign in_range = ((NODE_ID_W + 1)'(src) < (NODE_ID_W + 1)'(NODE_COUNT)) &&
                    ((NODE_ID_W + 1)'(dst) < (NODE_ID_W + 1)'(NODE_COUNT));

  // An edge counts as progress only when it marks a node not yet seen.
  always_comb begin
    hit_sure  = 1'b0;
    hit_maybe = 1'b0;
    if (rd_valid_r && in_range) begin
      if (use_sure_r[rd_idx_r]) begin
        hit_sure = seen_sure_r[src_i] && !seen_sure_r[dst_i];
      end
      if (use_maybe_r[rd_idx_r]) begin
        hit_maybe = seen_maybe_r[src_i] && !seen_maybe_r[dst_i];
      end
    end
    seen_sure_nxt  = seen_sure_r;
    seen_maybe_nxt = seen_maybe_r;
    if (hit_sure) begin
      seen_sure_nxt[dst_i] = 1'b1;
    end
    if (hit_maybe) begin
      seen_maybe_nxt[dst_i] = 1'b1;
    end
  end

  assign status.last_edge = (edge_cnt_r == EDGE_W'(EDGE_COUNT - 1));
  assign status.changed   = changed_r || hit_sure || hit_maybe;

  assign undecided = ends_r & ~seen_sure_r & seen_maybe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      edge_cnt_r <= '0;
      changed_r  <= 1'b0;
    end else begin
      rd_valid_r <= cmd.sweep;
      if (cmd.load_query) begin
        edge_cnt_r <= '0;
        changed_r  <= 1'b0;
      end else begin
        if (cmd.sweep) begin
          edge_cnt_r <= status.last_edge ? '0 : edge_cnt_r + 1'b1;
        end
        changed_r <= cmd.restart ? 1'b0 : status.changed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      use_sure_r   <= in_sure_edges[EDGE_COUNT-1:0];
      use_maybe_r  <= in_middle_edges[EDGE_COUNT-1:0] & ~in_absent_edges[EDGE_COUNT-1:0];
      ends_r       <= in_end_nodes[NODE_COUNT-1:0];
      seen_sure_r  <= in_start_nodes[NODE_COUNT-1:0];
      seen_maybe_r <= in_start_nodes[NODE_COUNT-1:0];
    end else begin
      seen_sure_r  <= seen_sure_nxt;
      seen_maybe_r <= seen_maybe_nxt;
    end
    if (cmd.finish) begin
      out_decided_r <= (undecided == '0);
      out_reached_r <= (undecided == '0) ? SET_W'(ends_r & seen_sure_r) : '0;
    end
  end

  assign out_decided     = out_decided_r;
  assign out_reached_set = out_reached_r;

endmodule

// ===== sv/edge_set_reachability_classifier.sv =====
// Channel   Handshake             Payload
// input     start high, busy low  in_kind, in_edge_index/source/target, in_*_edges/nodes
// result    out_valid for 1 cycle out_decided, out_reached_set
//
// A load transaction writes one edge table entry at the accepting edge; busy stays low.
// A query sweeps the edge table one edge per cycle, updating both closures together,
// and repeats the sweep until a pass adds no node.
// The result strobe rises in the cycle busy falls; the receiver cannot stall it.
// Reset is synchronous and clears the control state; the edge table is not cleared.
module edge_set_reachability_classifier
  import esr_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int EDGE_COUNT = 64
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic [NODE_ID_W-1:0] in_edge_index,
  input  logic [NODE_ID_W-1:0] in_edge_source,
  input  logic [NODE_ID_W-1:0] in_edge_target,
  input  logic [SET_W-1:0]     in_sure_edges,
  input  logic [SET_W-1:0]     in_absent_edges,
  input  logic [SET_W-1:0]     in_middle_edges,
  input  logic [SET_W-1:0]     in_start_nodes,
  input  logic [SET_W-1:0]     in_end_nodes,
  output logic                 out_valid,
  output logic                 out_decided,
  output logic [SET_W-1:0]     out_reached_set
);

  esr_cmd_t    cmd;
  esr_status_t status;

  esr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  esr_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .EDGE_COUNT (EDGE_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_edge_index   (in_edge_index),
    .in_edge_source  (in_edge_source),
    .in_edge_target  (in_edge_target),
    .in_sure_edges   (in_sure_edges),
    .in_absent_edges (in_absent_edges),
    .in_middle_edges (in_middle_edges),
    .in_start_nodes  (in_start_nodes),
    .in_end_nodes    (in_end_nodes),
    .out_decided     (out_decided),
    .out_reached_set (out_reached_set)
  );

`ifndef SYNTHESIS
  a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without a query in progress");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind |=> busy)
    else $error("accepted query did not start");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_kind |=> !busy && !out_valid)
    else $error("load transaction disturbed the controller");

  a_sweep_commands_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep, cmd.restart, cmd.finish, cmd.load_query}))
    else $error("conflicting datapath commands");
`endif

endmodule
